/* rtl/olir_pkg.sv */
// ============================================================================
// olir_pkg: shared types and constants of the ordered list
// Holds the list size, the request and status codes, the per-cell command
// and the decode bundle passed from the controller to the top level.
// ============================================================================
package olir_pkg;

   localparam int DEPTH = 16;
   localparam int WIDTH = 32;

   // Fixed widths of the request and response fields.
   localparam int POS_W = 5;
   localparam int ELEM_W = 32;
   localparam int COUNT_OUT_W = 5;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_INSERT = 3'd4,
      OP_REMOVE = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_ZERO
   } cell_cmd_type;

   typedef struct packed {
      status_type            status;
      logic                  rd_en;
      logic [IDX_W-1:0]      rd_idx;
      logic [CNT_W-1:0]      next_count;
   } decode_type;

   // Fit a request word to the stored width.
   function automatic logic [WIDTH-1:0] to_word(input logic [ELEM_W-1:0] v);
      logic [WIDTH-1:0] w;
      w = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (i < ELEM_W) begin
            w[i] = v[i];
         end
      end
      return w;
   endfunction

   // Fit a stored word to the response field.
   function automatic logic [ELEM_W-1:0] to_elem(input logic [WIDTH-1:0] w);
      logic [ELEM_W-1:0] v;
      v = '0;
      for (int i = 0; i < ELEM_W; i++) begin
         if (i < WIDTH) begin
            v[i] = w[i];
         end
      end
      return v;
   endfunction

endpackage

/* rtl/ordered_list_insert_remove.sv */
// ============================================================================
// ordered_list_insert_remove: bounded ordered list built as a row of slots
// Push, pop, get, set, insert, remove and clear on a list of DEPTH words.
// ============================================================================
// The response is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless the response stalls; each slot
// shifts, loads or holds at once, so insert and remove cost no more than get.
// Reset clears the fill count and the response valid flag; slot contents are
// left as they are and are never read before they were written.
module ordered_list_insert_remove (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_type,
   input  logic [olir_pkg::POS_W-1:0]         req_position,
   input  logic [olir_pkg::ELEM_W-1:0]        req_elem_value,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [olir_pkg::ELEM_W-1:0]        rsp_read_value,
   output logic [olir_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                               rsp_is_empty
);

   // Fill count of the list.
   logic [olir_pkg::CNT_W-1:0] count_ff;
   logic [olir_pkg::CNT_W-1:0] count_in;

   // Response register. It parts the two sides: a new request is taken as
   // soon as the waiting response leaves, in the same cycle.
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [1:0]                         rsp_status_ff;
   logic [olir_pkg::ELEM_W-1:0]        rsp_read_value_ff;
   logic [olir_pkg::COUNT_OUT_W-1:0]   rsp_entry_count_ff;
   logic                               rsp_is_empty_ff;

   logic                               accept;
   olir_pkg::decode_type               dec;
   olir_pkg::cell_cmd_type             cmds [olir_pkg::DEPTH];
   logic [olir_pkg::WIDTH-1:0]         load_word;
   logic [olir_pkg::WIDTH-1:0]         slot_q [olir_pkg::DEPTH];
   logic [olir_pkg::ELEM_W-1:0]        read_word;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign load_word = olir_pkg::to_word(req_elem_value);

   // The decoder checks the request against the count and steers the slots.
   olir_ctrl u_ctrl (
      .go       (accept),
      .op_code  (req_type),
      .position (req_position),
      .count    (count_ff),
      .dec      (dec),
      .cmds     (cmds)
   );

   // The row of slots. Each slot sees its two neighbors; the ends see zero.
   // Insert moves words toward the high end, remove toward the low end.
   for (genvar g = 0; g < olir_pkg::DEPTH; g++) begin : g_slot
      logic [olir_pkg::WIDTH-1:0] lower_word;
      logic [olir_pkg::WIDTH-1:0] upper_word;

      if (g == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_inner_lo
         assign lower_word = slot_q[g-1];
      end

      if (g == olir_pkg::DEPTH - 1) begin : g_last
         assign upper_word = '0;
      end else begin : g_inner_hi
         assign upper_word = slot_q[g+1];
      end

      olir_cell u_cell (
         .clock      (clock),
         .cmd        (cmds[g]),
         .load_word  (load_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word_q     (slot_q[g])
      );
   end

   // Pop, get and remove return the word that the slot holds before this
   // cycle's update; every other request returns zero.
   assign read_word = dec.rd_en ? olir_pkg::to_elem(slot_q[dec.rd_idx]) : '0;

   assign count_in     = accept ? dec.next_count : count_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= dec.status;
         rsp_read_value_ff  <= read_word;
         rsp_entry_count_ff <= olir_pkg::COUNT_OUT_W'(dec.next_count);
         rsp_is_empty_ff    <= (dec.next_count == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

endmodule

/* rtl/olir_cell.sv */
// ============================================================================
// olir_cell: one storage slot of the list
// Holds one word and each cycle keeps it, loads the request word, takes the
// word of a neighbor slot, or clears it.
// ============================================================================
module olir_cell (
   input  logic                         clock,
   input  olir_pkg::cell_cmd_type       cmd,
   input  logic [olir_pkg::WIDTH-1:0]   load_word,
   input  logic [olir_pkg::WIDTH-1:0]   lower_word,
   input  logic [olir_pkg::WIDTH-1:0]   upper_word,
   output logic [olir_pkg::WIDTH-1:0]   word_q
);

   logic [olir_pkg::WIDTH-1:0] word_ff;
   logic [olir_pkg::WIDTH-1:0] word_in;

   always_comb begin
      unique case (cmd)
         olir_pkg::CELL_LOAD:       word_in = load_word;
         olir_pkg::CELL_SHIFT_UP:   word_in = lower_word;
         olir_pkg::CELL_SHIFT_DOWN: word_in = upper_word;
         olir_pkg::CELL_ZERO:       word_in = '0;
         default:                   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_q = word_ff;

endmodule

/* rtl/olir_ctrl.sv */
// ============================================================================
// olir_ctrl: request decoder of the list
// Checks a request against the fill count, picks its status and new count,
// and gives every slot its command for this cycle.
// ============================================================================
module olir_ctrl (
   input  logic                              go,
   input  logic [2:0]                        op_code,
   input  logic [olir_pkg::POS_W-1:0]        position,
   input  logic [olir_pkg::CNT_W-1:0]        count,
   output olir_pkg::decode_type              dec,
   output olir_pkg::cell_cmd_type            cmds [olir_pkg::DEPTH]
);

   logic [olir_pkg::CMP_W-1:0] pos_x;
   logic [olir_pkg::CMP_W-1:0] cnt_x;
   logic [olir_pkg::CMP_W-1:0] last_x;
   logic                       full;
   logic                       empty;
   logic                       ok;
   olir_pkg::op_type           op;

   assign op     = olir_pkg::op_type'(op_code);
   assign pos_x  = olir_pkg::CMP_W'(position);
   assign cnt_x  = olir_pkg::CMP_W'(count);
   assign last_x = cnt_x - olir_pkg::CMP_W'(1);
   assign full   = (count == olir_pkg::CNT_W'(olir_pkg::DEPTH));
   assign empty  = (count == '0);
   assign ok     = (dec.status == olir_pkg::ST_OK);

   always_comb begin
      dec.status     = olir_pkg::ST_OK;
      dec.rd_en      = 1'b0;
      dec.rd_idx     = olir_pkg::IDX_W'(position);
      dec.next_count = count;
      unique case (op)
         olir_pkg::OP_PUSH: begin
            if (full) begin
               dec.status = olir_pkg::ST_FULL;
            end else begin
               dec.next_count = count + olir_pkg::CNT_W'(1);
            end
         end
         olir_pkg::OP_POP: begin
            dec.rd_idx = olir_pkg::IDX_W'(count - olir_pkg::CNT_W'(1));
            if (empty) begin
               dec.status = olir_pkg::ST_EMPTY;
            end else begin
               dec.rd_en      = 1'b1;
               dec.next_count = count - olir_pkg::CNT_W'(1);
            end
         end
         olir_pkg::OP_GET: begin
            if (pos_x >= cnt_x) begin
               dec.status = olir_pkg::ST_BADPOS;
            end else begin
               dec.rd_en = 1'b1;
            end
         end
         olir_pkg::OP_SET: begin
            if (pos_x >= cnt_x) begin
               dec.status = olir_pkg::ST_BADPOS;
            end
         end
         olir_pkg::OP_INSERT: begin
            if (pos_x > cnt_x) begin
               dec.status = olir_pkg::ST_BADPOS;
            end else if (full) begin
               dec.status = olir_pkg::ST_FULL;
            end else begin
               dec.next_count = count + olir_pkg::CNT_W'(1);
            end
         end
         olir_pkg::OP_REMOVE: begin
            if (pos_x >= cnt_x) begin
               dec.status = olir_pkg::ST_BADPOS;
            end else begin
               dec.rd_en      = 1'b1;
               dec.next_count = count - olir_pkg::CNT_W'(1);
            end
         end
         olir_pkg::OP_CLEAR: begin
            dec.next_count = '0;
         end
         default: begin
         end
      endcase
   end

   // Per-slot commands; each slot compares its own index only.
   always_comb begin
      for (int i = 0; i < olir_pkg::DEPTH; i++) begin
         logic [olir_pkg::CMP_W-1:0] idx;
         idx     = olir_pkg::CMP_W'(i);
         cmds[i] = olir_pkg::CELL_HOLD;
         if (go && ok) begin
            unique case (op)
               olir_pkg::OP_PUSH: begin
                  if (idx == cnt_x) cmds[i] = olir_pkg::CELL_LOAD;
               end
               olir_pkg::OP_POP: begin
                  if (idx == last_x) cmds[i] = olir_pkg::CELL_ZERO;
               end
               olir_pkg::OP_SET: begin
                  if (idx == pos_x) cmds[i] = olir_pkg::CELL_LOAD;
               end
               olir_pkg::OP_INSERT: begin
                  if (idx == pos_x) begin
                     cmds[i] = olir_pkg::CELL_LOAD;
                  end else if (idx > pos_x && idx <= cnt_x) begin
                     cmds[i] = olir_pkg::CELL_SHIFT_UP;
                  end
               end
               olir_pkg::OP_REMOVE: begin
                  if (idx == last_x) begin
                     cmds[i] = olir_pkg::CELL_ZERO;
                  end else if (idx >= pos_x && idx < last_x) begin
                     cmds[i] = olir_pkg::CELL_SHIFT_DOWN;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

/* bench/ordered_list_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// ordered_list_checker: response scoreboard for the ordered list
// Watches both handshakes and keeps its own copy of the list. It builds the
// expected response of every accepted request and compares each accepted
// response, field by field, with the oldest one still waiting.
// ============================================================================
module ordered_list_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [2:0]                         req_type,
   input  logic [olir_pkg::POS_W-1:0]         req_position,
   input  logic [olir_pkg::ELEM_W-1:0]        req_elem_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [1:0]                         rsp_status,
   input  logic [olir_pkg::ELEM_W-1:0]        rsp_read_value,
   input  logic [olir_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   input  logic                               rsp_is_empty,
   output int                                 mismatches,
   output int                                 replies_pending,
   output int                                 replies_checked,
   output int                                 full_refusals,
   output int                                 empty_refusals,
   output int                                 position_refusals
);

   typedef struct packed {
      olir_pkg::status_type                status;
      logic [olir_pkg::ELEM_W-1:0]         read_value;
      logic [olir_pkg::COUNT_OUT_W-1:0]    entry_count;
      logic                                is_empty;
   } list_reply_type;

   logic [olir_pkg::WIDTH-1:0]  list_words [olir_pkg::DEPTH];
   int                          fill_count;
   list_reply_type              expected_replies [$];
   list_reply_type              oldest_reply;

   // Applies one request to the shadow list and queues the response it owes.
   task automatic apply_request(input logic [2:0] code,
                                input logic [olir_pkg::POS_W-1:0] pos_in,
                                input logic [olir_pkg::ELEM_W-1:0] word_in);
      list_reply_type reply;
      int             pos;
      int             i;
      reply.status = olir_pkg::ST_OK;
      reply.read_value = '0;
      pos = int'(pos_in);
      case (code)
         olir_pkg::OP_PUSH: begin
            if (fill_count >= olir_pkg::DEPTH) begin
               reply.status = olir_pkg::ST_FULL;
            end else begin
               list_words[fill_count] = word_in;
               fill_count++;
            end
         end
         olir_pkg::OP_POP: begin
            if (fill_count == 0) begin
               reply.status = olir_pkg::ST_EMPTY;
            end else begin
               reply.read_value = list_words[fill_count-1];
               list_words[fill_count-1] = '0;
               fill_count--;
            end
         end
         olir_pkg::OP_GET: begin
            if (pos >= fill_count) begin
               reply.status = olir_pkg::ST_BADPOS;
            end else begin
               reply.read_value = list_words[pos];
            end
         end
         olir_pkg::OP_SET: begin
            if (pos >= fill_count) begin
               reply.status = olir_pkg::ST_BADPOS;
            end else begin
               list_words[pos] = word_in;
            end
         end
         olir_pkg::OP_INSERT: begin
            if (pos > fill_count) begin
               reply.status = olir_pkg::ST_BADPOS;
            end else if (fill_count >= olir_pkg::DEPTH) begin
               reply.status = olir_pkg::ST_FULL;
            end else begin
               for (i = fill_count; i > pos; i--) begin
                  list_words[i] = list_words[i-1];
               end
               list_words[pos] = word_in;
               fill_count++;
            end
         end
         olir_pkg::OP_REMOVE: begin
            if (pos >= fill_count) begin
               reply.status = olir_pkg::ST_BADPOS;
            end else begin
               reply.read_value = list_words[pos];
               for (i = pos; i + 1 < fill_count; i++) begin
                  list_words[i] = list_words[i+1];
               end
               list_words[fill_count-1] = '0;
               fill_count--;
            end
         end
         olir_pkg::OP_CLEAR: begin
            fill_count = 0;
         end
         default: begin
         end
      endcase
      reply.entry_count = olir_pkg::COUNT_OUT_W'(fill_count);
      reply.is_empty = (fill_count == 0);
      case (reply.status)
         olir_pkg::ST_FULL:   full_refusals++;
         olir_pkg::ST_EMPTY:  empty_refusals++;
         olir_pkg::ST_BADPOS: position_refusals++;
         default: begin
         end
      endcase
      expected_replies.push_back(reply);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_replies.delete();
         fill_count = 0;
         for (int k = 0; k < olir_pkg::DEPTH; k++) begin
            list_words[k] = '0;
         end
         mismatches = 0;
         replies_checked = 0;
         full_refusals = 0;
         empty_refusals = 0;
         position_refusals = 0;
      end else begin
         // A request and the response of an earlier one may meet at one edge.
         if (req_valid && req_ready) begin
            apply_request(req_type, req_position, req_elem_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t ns: response with none expected, %s %0h",
                        $time, "expected nothing, actual", rsp_read_value);
               mismatches++;
            end else begin
               oldest_reply = expected_replies.pop_front();
               compare_field("status", 32'(oldest_reply.status), 32'(rsp_status));
               compare_field("read_value", oldest_reply.read_value, rsp_read_value);
               compare_field("entry_count", 32'(oldest_reply.entry_count),
                             32'(rsp_entry_count));
               compare_field("is_empty", 32'(oldest_reply.is_empty), 32'(rsp_is_empty));
               replies_checked++;
            end
         end
      end
      replies_pending <= expected_replies.size();
   end

endmodule

/* bench/ordered_list_insert_remove_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// ordered_list_insert_remove_tb: request stimulus and verdict for the list
// Drives a directed pass over the corner cases of the list, then phases of
// random fill, drain and mixed traffic with random gaps on both sides, one
// long response hold-off, and a scoreboard that checks every response.
// ============================================================================
module ordered_list_insert_remove_tb;

   // The spare request code that the block must treat as a no-op.
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   localparam int RANDOM_REQUESTS = 1620;
   localparam int CYCLE_LIMIT = 200000;
   // The response side holds off for a long stretch here, so that the
   // block fills its output stage and has to stall the request side.
   localparam int HOLD_START = 1200;
   localparam int HOLD_LEN = 120;
   // Stretches of the run in which one side or the other inserts no gap.
   localparam int STEADY_RSP_START = 2000;
   localparam int STEADY_RSP_END = 2400;
   localparam int STEADY_REQ_START = 700;
   localparam int STEADY_REQ_END = 1000;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [2:0]                           req_type = '0;
   logic [olir_pkg::POS_W-1:0]           req_position = '0;
   logic [olir_pkg::ELEM_W-1:0]          req_elem_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [1:0]                           rsp_status;
   logic [olir_pkg::ELEM_W-1:0]          rsp_read_value;
   logic [olir_pkg::COUNT_OUT_W-1:0]     rsp_entry_count;
   logic                                 rsp_is_empty;

   int mismatches;
   int replies_pending;
   int replies_checked;
   int full_refusals;
   int empty_refusals;
   int position_refusals;

   int requests_sent = 0;
   int sent_by_code [8];
   int cycle_count = 0;
   int ready_cycle = 0;

   ordered_list_insert_remove DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_elem_value  (req_elem_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   ordered_list_checker list_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .mismatches        (mismatches),
      .replies_pending   (replies_pending),
      .replies_checked   (replies_checked),
      .full_refusals     (full_refusals),
      .empty_refusals    (empty_refusals),
      .position_refusals (position_refusals)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a correct run ends long before this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, replies_pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Response side. It counts its own cycles so that the long hold-off and
   // the stall-free stretch land at fixed points of the run, and stalls at
   // random with a chance of 18 in a hundred everywhere else.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_cycle <= 0;
      end else begin
         ready_cycle <= ready_cycle + 1;
         if (ready_cycle >= HOLD_START && ready_cycle < HOLD_START + HOLD_LEN) begin
            rsp_ready <= 1'b0;
         end else if (ready_cycle >= STEADY_RSP_START && ready_cycle < STEADY_RSP_END) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 18);
         end
      end
   end

   // Offers one request and holds it until the block takes it. Valid is
   // only lowered when a gap follows, so back-to-back requests keep valid
   // high across the edge.
   task automatic send_request(input logic [2:0] code,
                               input logic [olir_pkg::POS_W-1:0] pos,
                               input logic [olir_pkg::ELEM_W-1:0] word, input int gap);
      req_valid <= 1'b1;
      req_type <= code;
      req_position <= pos;
      req_elem_value <= word;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      requests_sent++;
      sent_by_code[code]++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Picks a request code. Phase 0 grows the list, phase 1 shrinks it and
   // phase 2 mixes everything, so the fill level sweeps from empty to full.
   function automatic logic [2:0] choose_request(input int phase);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         return olir_pkg::OP_CLEAR;
      end else if (roll < 4) begin
         return REQ_UNUSED;
      end
      case (phase)
         0: begin
            if (roll < 40) return olir_pkg::OP_PUSH;
            if (roll < 72) return olir_pkg::OP_INSERT;
            if (roll < 82) return olir_pkg::OP_GET;
            if (roll < 92) return olir_pkg::OP_SET;
            if (roll < 96) return olir_pkg::OP_POP;
            return olir_pkg::OP_REMOVE;
         end
         1: begin
            if (roll < 38) return olir_pkg::OP_POP;
            if (roll < 72) return olir_pkg::OP_REMOVE;
            if (roll < 84) return olir_pkg::OP_GET;
            if (roll < 92) return olir_pkg::OP_SET;
            return olir_pkg::OP_PUSH;
         end
         default: begin
            return olir_pkg::op_type'($urandom_range(0, 5));
         end
      endcase
   endfunction

   // Positions lean toward small indexes so that most requests hit a live
   // entry; a few go past the end and a few use the full field width.
   function automatic logic [olir_pkg::POS_W-1:0] choose_position();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
         return olir_pkg::POS_W'($urandom_range(0, $urandom_range(0, olir_pkg::DEPTH)));
      end else if (roll < 94) begin
         return olir_pkg::POS_W'($urandom_range(0, olir_pkg::DEPTH + 1));
      end
      return olir_pkg::POS_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [olir_pkg::ELEM_W-1:0] choose_word();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return '0;
      end else if (roll < 16) begin
         return '1;
      end
      return $urandom;
   endfunction

   function automatic int choose_gap(input int index);
      if (index >= STEADY_REQ_START && index < STEADY_REQ_END) begin
         return 0;
      end
      return ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : 0;
   endfunction

   initial begin
      int n;
      int phase;
      for (int k = 0; k < 8; k++) begin
         sent_by_code[k] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pass. First the refusals on an empty list: pop gives the
      // empty status, and get, set, remove and an insert past the end give a
      // bad position.
      send_request(olir_pkg::OP_POP, 5'd0, '0, 0);
      send_request(olir_pkg::OP_GET, 5'd0, '0, 1);
      send_request(olir_pkg::OP_REMOVE, 5'd0, '0, 0);
      send_request(olir_pkg::OP_SET, 5'd0, 32'h1234_5678, 0);
      send_request(olir_pkg::OP_INSERT, 5'd1, 32'hdead_beef, 0);
      // Insert at the end of an empty list is legal; then the extreme words.
      send_request(olir_pkg::OP_INSERT, 5'd0, 32'hffff_ffff, 0);
      send_request(olir_pkg::OP_PUSH, 5'd0, 32'h0000_0000, 0);
      send_request(olir_pkg::OP_SET, 5'd1, 32'ha5a5_a5a5, 2);
      send_request(olir_pkg::OP_GET, 5'd31, '0, 0);
      send_request(olir_pkg::OP_INSERT, 5'd1, 32'h5a5a_5a5a, 0);
      send_request(olir_pkg::OP_REMOVE, 5'd1, '0, 0);
      send_request(REQ_UNUSED, 5'd31, 32'hffff_ffff, 0);
      // Fill the list to the top, then ask for more: push and insert at the
      // end are refused as full, an insert past the end as a bad position.
      for (int k = 2; k < olir_pkg::DEPTH; k++) begin
         send_request(olir_pkg::OP_PUSH, '0, 32'h0101_0101 * k, 0);
      end
      send_request(olir_pkg::OP_PUSH, '0, 32'h7777_7777, 0);
      send_request(olir_pkg::OP_INSERT, 5'd16, 32'h8888_8888, 0);
      send_request(olir_pkg::OP_INSERT, 5'd17, 32'h9999_9999, 0);
      send_request(olir_pkg::OP_GET, 5'd16, '0, 0);
      send_request(olir_pkg::OP_GET, 5'd15, '0, 0);
      send_request(olir_pkg::OP_REMOVE, 5'd15, '0, 0);
      send_request(olir_pkg::OP_REMOVE, 5'd0, '0, 0);
      send_request(olir_pkg::OP_POP, '0, '0, 0);
      // Clear keeps the contents but empties the list.
      send_request(olir_pkg::OP_CLEAR, '0, '0, 0);
      send_request(olir_pkg::OP_POP, '0, '0, 1);

      // Random traffic in phases of a few dozen requests each.
      phase = 0;
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) begin
            phase = (n / 40 % 5 == 4) ? 2 : (n / 40) % 2;
         end
         send_request(choose_request(phase), choose_position(), choose_word(),
                      choose_gap(n));
      end
      req_valid <= 1'b0;
      @(posedge clock);

      // Drain: wait for every response, then for any stray ones.
      while (replies_pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);

      $display("Covered %0d requests: push %0d, pop %0d, get %0d, set %0d, insert %0d,",
               requests_sent, sent_by_code[olir_pkg::OP_PUSH],
               sent_by_code[olir_pkg::OP_POP], sent_by_code[olir_pkg::OP_GET],
               sent_by_code[olir_pkg::OP_SET], sent_by_code[olir_pkg::OP_INSERT]);
      $write("remove %0d, clear %0d, unused %0d; ",
             sent_by_code[olir_pkg::OP_REMOVE], sent_by_code[olir_pkg::OP_CLEAR],
             sent_by_code[REQ_UNUSED]);
      $display("%0d responses checked, %0d full, %0d empty, %0d bad position",
               replies_checked, full_refusals, empty_refusals, position_refusals);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
